// ===== hdl/prt_pkg.sv =====
`default_nettype none

package prt_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_FIND   = 2'd1;
    localparam logic [1:0] REQ_PURGE  = 2'd2;

    localparam logic [1:0] RC_OK   = 2'd0;
    localparam logic [1:0] RC_FULL = 2'd1;
    localparam logic [1:0] RC_NONE = 2'd2;

    localparam logic [1:0] ST_READY      = 2'd0;
    localparam logic [1:0] ST_TERMINATED = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] proc_id;
        logic [7:0]  prio_in;
        logic [1:0]  state_in;
    } req_t;

    typedef struct packed {
        logic [1:0]  result_code;
        logic [15:0] found_id;
        logic [7:0]  found_prio;
        logic [4:0]  removed_count;
    } rsp_t;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
        logic [1:0]  status;
    } entry_t;

endpackage

`default_nettype wire

// ===== hdl/priority_ready_table.sv =====
// channel | valid     | stall     | payload      | transfer
// request | req_valid | req_stall | req (req_t)  | req_valid && !req_stall
// result  | rsp_valid | rsp_stall | rsp (rsp_t)  | rsp_valid && !rsp_stall
//
// one request at a time; the table memory has one read and one write port,
// so every scan or shift steps through the entries one at a time
// insert moves lower-priority entries down; find reads entries up to a ready one;
// purge reads every filled entry; unused codes and full or empty cases go straight to S_RESP
// reset empties the table at once; a stalled result holds the next one in S_RESP
`default_nettype none

module priority_ready_table
    import prt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  wire  clk,
    input  wire  rst_n,
    input  wire  req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  wire  rsp_stall,
    output rsp_t rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_FILL = CW'(TABLE_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INS   = 3'd1;
    localparam logic [2:0] S_PUT   = 3'd2;
    localparam logic [2:0] S_FIND  = 3'd3;
    localparam logic [2:0] S_PURGE = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    entry_t table_mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] wr_reg, wr_next;
    logic [CW-1:0] kept;
    req_t          cur_reg, cur_next;
    rsp_t          res_reg, res_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    logic          we;
    logic [AW-1:0] wa;
    logic [AW-1:0] ra;
    entry_t        wd;
    entry_t        new_entry;

    assign new_entry = '{id: cur_reg.proc_id, prio: cur_reg.prio_in, status: cur_reg.state_in};
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            table_mem[wa] <= wd;
        end
        rd_data_reg <= table_mem[ra];
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ptr_next       = ptr_reg;
        wr_next        = wr_reg;
        cur_next       = cur_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        we             = 1'b0;
        wa             = '0;
        wd             = new_entry;
        ra             = '0;
        kept           = wr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cur_next   = req;
                    res_next   = '0;
                    state_next = S_RESP;
                    case (req.req_type)
                        REQ_INSERT:
                        begin
                            if (fill_reg == FULL_FILL)
                            begin
                                res_next.result_code = RC_FULL;
                            end
                            else if (fill_reg == '0)
                            begin
                                we        = 1'b1;
                                wd        = '{id: req.proc_id, prio: req.prio_in,
                                              status: req.state_in};
                                fill_next = fill_reg + CW'(1);
                            end
                            else
                            begin
                                ra         = AW'(fill_reg - CW'(1));
                                ptr_next   = fill_reg;
                                state_next = S_INS;
                            end
                        end
                        REQ_FIND:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_next.result_code = RC_NONE;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_FIND;
                            end
                        end
                        REQ_PURGE:
                        begin
                            if (fill_reg != '0)
                            begin
                                ptr_next   = '0;
                                wr_next    = '0;
                                state_next = S_PURGE;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_INS:
            begin
                we = 1'b1;
                wa = ptr_reg[AW-1:0];
                if (rd_data_reg.prio < cur_reg.prio_in)
                begin
                    wd       = rd_data_reg;
                    ptr_next = ptr_reg - CW'(1);
                    if (ptr_reg == CW'(1))
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        ra = AW'(ptr_reg - CW'(2));
                    end
                end
                else
                begin
                    fill_next  = fill_reg + CW'(1);
                    state_next = S_RESP;
                end
            end
            S_PUT:
            begin
                we         = 1'b1;
                wa         = ptr_reg[AW-1:0];
                fill_next  = fill_reg + CW'(1);
                state_next = S_RESP;
            end
            S_FIND:
            begin
                if (rd_data_reg.status == ST_READY)
                begin
                    res_next.found_id   = rd_data_reg.id;
                    res_next.found_prio = rd_data_reg.prio;
                    state_next          = S_RESP;
                end
                else if (ptr_reg + CW'(1) == fill_reg)
                begin
                    res_next.result_code = RC_NONE;
                    state_next           = S_RESP;
                end
                else
                begin
                    ra       = AW'(ptr_reg + CW'(1));
                    ptr_next = ptr_reg + CW'(1);
                end
            end
            S_PURGE:
            begin
                if (rd_data_reg.status != ST_TERMINATED)
                begin
                    we   = 1'b1;
                    wa   = wr_reg[AW-1:0];
                    wd   = rd_data_reg;
                    kept = wr_reg + CW'(1);
                end
                wr_next = kept;
                if (ptr_reg + CW'(1) == fill_reg)
                begin
                    fill_next              = kept;
                    res_next.removed_count = 5'(fill_reg - kept);
                    state_next             = S_RESP;
                end
                else
                begin
                    ra       = AW'(ptr_reg + CW'(1));
                    ptr_next = ptr_reg + CW'(1);
                end
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            ptr_reg       <= '0;
            wr_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ptr_reg       <= ptr_next;
            wr_reg        <= wr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

endmodule

`default_nettype wire

// ===== test/tb_priority_ready_table.sv =====
`timescale 1ns / 100ps

module tb_priority_ready_table;
    import prt_pkg::*;

    localparam int DEPTH          = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS   = 420;
    localparam int TAIL_ITEMS     = 60;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int SETTLE_CYCLES  = 40;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_WAITING = 2'd2;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    req_t   pending_req_q[$];
    rsp_t   expected_rsp_q[$];
    entry_t table_entry[DEPTH];
    int     table_fill = 0;

    logic req_fire = 1'b0;
    logic all_drained = 1'b0;
    logic idle_mode = 1'b1;
    logic calm_tail = 1'b0;
    logic stim_loaded = 1'b0;
    int   send_gap = 0;
    int   stall_left = 0;
    int   cycle_count = 0;
    int   quiet_cycles = 0;
    int   fail_count = 0;
    int   rsp_seen = 0;
    int   req_sent = 0;
    int   full_rejects = 0;
    int   empty_finds = 0;
    int   purged_total = 0;
    int   kind_count[4] = '{0, 0, 0, 0};

    priority_ready_table #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic rsp_t apply_request(input req_t r);
        rsp_t res;
        int   pos;
        int   kept;
        logic hit;
        res = '0;
        hit = 1'b0;
        case (r.req_type)
            REQ_INSERT:
            begin
                if (table_fill >= DEPTH)
                begin
                    res.result_code = RC_FULL;
                    full_rejects++;
                end
                else
                begin
                    pos = 0;
                    while (pos < table_fill && table_entry[pos].prio >= r.prio_in)
                        pos++;
                    for (int k = table_fill; k > pos; k--)
                        table_entry[k] = table_entry[k - 1];
                    table_entry[pos].id = r.proc_id;
                    table_entry[pos].prio = r.prio_in;
                    table_entry[pos].status = r.state_in;
                    table_fill++;
                end
            end
            REQ_FIND:
            begin
                res.result_code = RC_NONE;
                for (int k = 0; k < table_fill && !hit; k++)
                begin
                    if (table_entry[k].status == ST_READY)
                    begin
                        hit = 1'b1;
                        res.result_code = RC_OK;
                        res.found_id = table_entry[k].id;
                        res.found_prio = table_entry[k].prio;
                    end
                end
                if (!hit)
                    empty_finds++;
            end
            REQ_PURGE:
            begin
                kept = 0;
                for (int k = 0; k < table_fill; k++)
                begin
                    if (table_entry[k].status != ST_TERMINATED)
                    begin
                        table_entry[kept] = table_entry[k];
                        kept++;
                    end
                end
                res.removed_count = 5'(table_fill - kept);
                purged_total += table_fill - kept;
                table_fill = kept;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic string show_rsp(input rsp_t r);
        return $sformatf("code %0d id %h prio %0d removed %0d",
            r.result_code, r.found_id, r.found_prio, r.removed_count);
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    task automatic queue_request(input logic [1:0] kind, input logic [15:0] id,
                                 input logic [7:0] prio, input logic [1:0] st);
        req_t r;
        r.req_type = kind;
        r.proc_id = id;
        r.prio_in = prio;
        r.state_in = st;
        pending_req_q.push_back(r);
    endtask

    // request driver
    always @(negedge clk)
    begin : drive_req
        logic next_valid;
        req_t next_req;
        next_valid = req_valid;
        next_req = req;
        if (!rst_n)
        begin
            next_valid = 1'b0;
            next_req = '0;
        end
        else
        begin
            if (req_valid && req_fire)
                next_valid = 1'b0;
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_req_q.size() > 0)
                begin
                    next_req = pending_req_q.pop_front();
                    next_valid = 1'b1;
                    if (idle_mode && !calm_tail && $urandom_range(0, 3) == 0)
                        send_gap = $urandom_range(1, 11);
                end
            end
        end
        calm_tail <= stim_loaded && pending_req_q.size() < TAIL_ITEMS;
        req_valid <= next_valid;
        req <= next_req;
    end

    // result stall
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else if (!rsp_stall && idle_mode && !calm_tail && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= 1'b0;
    end

    // monitor and checker
    always @(posedge clk)
    begin : check_rsp
        rsp_t want;
        req_fire <= req_valid && !req_stall && rst_n;
        cycle_count++;
        if (cycle_count % 64 == 0)
            idle_mode <= ($urandom_range(0, 2) != 0);
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                rsp_seen++;
                if (expected_rsp_q.size() == 0)
                    note_failure($sformatf("unexpected result: %s", show_rsp(rsp)));
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.result_code !== want.result_code || rsp.found_id !== want.found_id
                        || rsp.found_prio !== want.found_prio
                        || rsp.removed_count !== want.removed_count)
                        note_failure($sformatf("result %0d: expected %s, got %s",
                            rsp_seen, show_rsp(want), show_rsp(rsp)));
                end
            end
            if (req_valid && !req_stall)
            begin
                req_sent++;
                kind_count[req.req_type]++;
                expected_rsp_q.push_back(apply_request(req));
            end
        end
        all_drained <= pending_req_q.size() == 0 && !req_valid && expected_rsp_q.size() == 0;
    end

    // watchdog on transfers
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          pick;
        logic [1:0]  kind;
        logic [7:0]  prio;
        logic [1:0]  st;
        int          free_budget;

        queue_request(REQ_FIND, 16'h0000, 8'h00, ST_READY);
        queue_request(REQ_PURGE, 16'h0000, 8'h00, ST_READY);
        queue_request(REQ_UNUSED, 16'hffff, 8'hff, ST_TERMINATED);
        queue_request(REQ_INSERT, 16'hffff, 8'hff, ST_RUNNING);
        queue_request(REQ_FIND, 16'h0000, 8'h00, ST_READY);
        queue_request(REQ_INSERT, 16'h0000, 8'h00, ST_READY);
        queue_request(REQ_FIND, 16'hffff, 8'hff, ST_TERMINATED);
        queue_request(REQ_INSERT, 16'h1234, 8'hff, ST_READY);
        queue_request(REQ_INSERT, 16'ha5a5, 8'h80, ST_TERMINATED);
        queue_request(REQ_INSERT, 16'h5a5a, 8'h80, ST_WAITING);
        queue_request(REQ_FIND, 16'h0000, 8'h00, ST_READY);
        queue_request(REQ_PURGE, 16'h0000, 8'h00, ST_READY);
        queue_request(REQ_PURGE, 16'hffff, 8'hff, ST_TERMINATED);
        // fill the remaining slots, then overflow
        for (int k = 0; k < DEPTH - 4; k++)
            queue_request(REQ_INSERT, 16'h0100 + 16'(k), 8'(k * 21), ST_TERMINATED);
        queue_request(REQ_INSERT, 16'hbeef, 8'hff, ST_READY);
        queue_request(REQ_FIND, 16'h0000, 8'h00, ST_READY);
        queue_request(REQ_PURGE, 16'h0000, 8'h00, ST_READY);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (!all_drained);
        @(posedge clk);

        // few live entries so purges keep the table from locking up full
        free_budget = 10;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if ((n / 30) % 2 == 0)
                kind = (pick < 85) ? REQ_INSERT : (pick < 95) ? REQ_FIND : REQ_UNUSED;
            else
                kind = (pick < 35) ? REQ_INSERT : (pick < 65) ? REQ_FIND :
                       (pick < 90) ? REQ_PURGE : REQ_UNUSED;
            case ($urandom_range(0, 3))
                0: prio = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
                1: prio = ($urandom_range(0, 1) != 0) ? 8'h80 : 8'h40;
                default: prio = 8'($urandom);
            endcase
            if (kind != REQ_INSERT)
                st = 2'($urandom);
            else if (free_budget > 0 && $urandom_range(0, 11) == 0)
            begin
                st = 2'($urandom_range(0, 2));
                free_budget--;
            end
            else
                st = ST_TERMINATED;
            queue_request(kind, 16'($urandom), prio, st);
        end
        stim_loaded = 1'b1;

        do
            @(negedge clk);
        while (!all_drained);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (expected_rsp_q.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_rsp_q.size()));
        $display("%0d requests: %0d inserts, %0d finds, %0d purges, %0d unused codes",
            req_sent, kind_count[REQ_INSERT], kind_count[REQ_FIND], kind_count[REQ_PURGE],
            kind_count[REQ_UNUSED]);
        $display("%0d results checked, %0d full rejects, %0d finds without ready, %0d purged",
            rsp_seen, full_rejects, empty_finds, purged_total);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
